@@ sv/bmh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

  // Heap geometry
  localparam int DEPTH     = 64;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int KEY_W     = 32;
  localparam int OUT_CNT_W = 7;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Read address selection
  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_DEL_LAST,
    ST_DEL_LOAD,
    ST_DN_CHK,
    ST_DN_LEFT,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    start_ins;  // load key, hole at end, count up
    logic    start_del;  // hole at root, count down
    logic    stat_we;
    status_t stat_val;
    rd_sel_t rd_sel;
    logic    cap_min;    // read data is the old root
    logic    cap_mkey;   // read data is the last entry
    logic    cap_left;   // read data is the left child
    logic    move_up;    // parent drops into hole, hole moves up
    logic    move_down;  // smaller child rises into hole, hole moves down
    logic    wr_final;   // moving key lands in hole
  } ctl_t;

  // Datapath status to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic has_left;
    logic up_less;    // moving key below parent
    logic pick_less;  // smaller child below moving key
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/bmh_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/bmh_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmh_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic signed [bmh_pkg::KEY_W-1:0] key_in,
  input  wire bmh_pkg::ctl_t                     ctl,
  output bmh_pkg::dp_stat_t                      st,
  output logic signed [bmh_pkg::KEY_W-1:0]      min_out,
  output logic        [1:0]                      status,
  output logic        [bmh_pkg::OUT_CNT_W-1:0]   count_out
);

  logic        [bmh_pkg::CNT_W-1:0]  count;
  logic        [bmh_pkg::ADDR_W-1:0] pos;
  logic signed [bmh_pkg::KEY_W-1:0]  mkey;
  logic signed [bmh_pkg::KEY_W-1:0]  lkey;
  logic signed [bmh_pkg::KEY_W-1:0]  minv;
  bmh_pkg::status_t                  stat;

  logic        [bmh_pkg::ADDR_W-1:0] parent;
  logic        [bmh_pkg::ADDR_W:0]   left_w;
  logic        [bmh_pkg::ADDR_W:0]   right_w;
  logic        [bmh_pkg::ADDR_W-1:0] left_idx;
  logic        [bmh_pkg::ADDR_W-1:0] right_idx;
  logic                              has_right;
  logic                              take_right;
  logic signed [bmh_pkg::KEY_W-1:0]  pick_key;
  logic        [bmh_pkg::ADDR_W-1:0] pick_idx;

  logic        [bmh_pkg::ADDR_W-1:0] raddr;
  logic        [bmh_pkg::ADDR_W-1:0] waddr;
  logic        [bmh_pkg::KEY_W-1:0]  wdata;
  logic                              we;
  logic        [bmh_pkg::KEY_W-1:0]  rdata_u;
  logic signed [bmh_pkg::KEY_W-1:0]  rdata;

  // Tree neighbors of the hole
  assign parent    = (pos - bmh_pkg::ADDR_W'(1)) >> 1;
  assign left_w    = {pos, 1'b1};
  assign right_w   = left_w + (bmh_pkg::ADDR_W + 1)'(1);
  assign left_idx  = left_w[bmh_pkg::ADDR_W-1:0];
  assign right_idx = right_w[bmh_pkg::ADDR_W-1:0];
  assign has_right = ((bmh_pkg::CNT_W + 1)'(right_w) < (bmh_pkg::CNT_W + 1)'(count));

  // Smaller child; ties go right
  assign rdata      = $signed(rdata_u);
  assign take_right = has_right && !(lkey < rdata);
  assign pick_key   = take_right ? rdata : lkey;
  assign pick_idx   = take_right ? right_idx : left_idx;

  assign st.full      = (count == bmh_pkg::CNT_W'(bmh_pkg::DEPTH));
  assign st.empty     = (count == '0);
  assign st.at_root   = (pos == '0);
  assign st.has_left  = ((bmh_pkg::CNT_W + 1)'(left_w) < (bmh_pkg::CNT_W + 1)'(count));
  assign st.up_less   = (mkey < rdata);
  assign st.pick_less = (pick_key < mkey);

  // Read address
  always_comb begin
    case (ctl.rd_sel)
      bmh_pkg::RD_ROOT:   raddr = '0;
      bmh_pkg::RD_LAST:   raddr = count[bmh_pkg::ADDR_W-1:0];
      bmh_pkg::RD_PARENT: raddr = parent;
      bmh_pkg::RD_LEFT:   raddr = left_idx;
      bmh_pkg::RD_RIGHT:  raddr = right_idx;
      default:            raddr = '0;
    endcase
  end

  // Write into the hole
  always_comb begin
    we    = ctl.move_up | ctl.move_down | ctl.wr_final;
    waddr = pos;
    if (ctl.move_up) begin
      wdata = rdata_u;
    end else if (ctl.move_down) begin
      wdata = pick_key;
    end else begin
      wdata = mkey;
    end
  end

  bmh_ram #(
    .WIDTH (bmh_pkg::KEY_W),
    .DEPTH (bmh_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_u)
  );

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.start_ins) begin
      count <= count + bmh_pkg::CNT_W'(1);
    end else if (ctl.start_del) begin
      count <= count - bmh_pkg::CNT_W'(1);
    end
  end

  // Hole position, keys and result fields
  always_ff @(posedge clk) begin
    if (ctl.start_ins) begin
      pos  <= count[bmh_pkg::ADDR_W-1:0];
      mkey <= key_in;
    end else if (ctl.start_del) begin
      pos <= '0;
    end else if (ctl.move_up) begin
      pos <= parent;
    end else if (ctl.move_down) begin
      pos <= pick_idx;
    end
    if (ctl.cap_mkey) begin
      mkey <= rdata;
    end
    if (ctl.cap_left) begin
      lkey <= rdata;
    end
    if (ctl.stat_we) begin
      stat <= ctl.stat_val;
      minv <= '0;
    end
    if (ctl.cap_min) begin
      minv <= rdata;
    end
  end

  assign min_out   = minv;
  assign status    = stat;
  assign count_out = bmh_pkg::OUT_CNT_W'(count);

endmodule

`default_nettype wire

@@ sv/bmh_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              cmd,
  input  wire bmh_pkg::dp_stat_t st,
  output bmh_pkg::ctl_t          ctl,
  output logic                   busy,
  output logic                   done
);

  bmh_pkg::state_t state;
  bmh_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.stat_val = bmh_pkg::STAT_OK;
    ctl.rd_sel   = bmh_pkg::RD_NONE;
    case (state)
      bmh_pkg::ST_IDLE: begin
        if (start) begin
          ctl.stat_we = 1'b1;
          if (cmd == bmh_pkg::CMD_INSERT) begin
            if (st.full) begin
              ctl.stat_val = bmh_pkg::STAT_FULL;
              state_next   = bmh_pkg::ST_FINISH;
            end else begin
              ctl.start_ins = 1'b1;
              state_next    = bmh_pkg::ST_INS_CHK;
            end
          end else begin
            if (st.empty) begin
              ctl.stat_val = bmh_pkg::STAT_EMPTY;
              state_next   = bmh_pkg::ST_FINISH;
            end else begin
              ctl.start_del = 1'b1;
              ctl.rd_sel    = bmh_pkg::RD_ROOT;
              state_next    = bmh_pkg::ST_DEL_LAST;
            end
          end
        end
      end
      // sift up: one read, one compare per level
      bmh_pkg::ST_INS_CHK: begin
        if (st.at_root) begin
          ctl.wr_final = 1'b1;
          state_next   = bmh_pkg::ST_FINISH;
        end else begin
          ctl.rd_sel = bmh_pkg::RD_PARENT;
          state_next = bmh_pkg::ST_INS_CMP;
        end
      end
      bmh_pkg::ST_INS_CMP: begin
        if (st.up_less) begin
          ctl.move_up = 1'b1;
          state_next  = bmh_pkg::ST_INS_CHK;
        end else begin
          ctl.wr_final = 1'b1;
          state_next   = bmh_pkg::ST_FINISH;
        end
      end
      // delete: take root, fetch last entry as the sinking key
      bmh_pkg::ST_DEL_LAST: begin
        ctl.cap_min = 1'b1;
        ctl.rd_sel  = bmh_pkg::RD_LAST;
        state_next  = bmh_pkg::ST_DEL_LOAD;
      end
      bmh_pkg::ST_DEL_LOAD: begin
        ctl.cap_mkey = 1'b1;
        state_next   = bmh_pkg::ST_DN_CHK;
      end
      // sift down: read left, read right, compare
      bmh_pkg::ST_DN_CHK: begin
        if (st.has_left) begin
          ctl.rd_sel = bmh_pkg::RD_LEFT;
          state_next = bmh_pkg::ST_DN_LEFT;
        end else begin
          ctl.wr_final = 1'b1;
          state_next   = bmh_pkg::ST_FINISH;
        end
      end
      bmh_pkg::ST_DN_LEFT: begin
        ctl.cap_left = 1'b1;
        ctl.rd_sel   = bmh_pkg::RD_RIGHT;
        state_next   = bmh_pkg::ST_DN_CMP;
      end
      bmh_pkg::ST_DN_CMP: begin
        if (st.pick_less) begin
          ctl.move_down = 1'b1;
          state_next    = bmh_pkg::ST_DN_CHK;
        end else begin
          ctl.wr_final = 1'b1;
          state_next   = bmh_pkg::ST_FINISH;
        end
      end
      bmh_pkg::ST_FINISH: begin
        state_next = bmh_pkg::ST_IDLE;
      end
      default: begin
        state_next = bmh_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != bmh_pkg::ST_IDLE);
  assign done = (state == bmh_pkg::ST_FINISH);

endmodule

`default_nettype wire

@@ sv/binary_min_heap.sv @@
// Binary min-heap of signed 32-bit keys, insert or delete-min per transfer.
// Insert sifts up, one parent read and compare per level climbed; delete-min reads the root,
// then the last entry, and sifts it down, reading left and right child per level (up to 5
// levels); an insert when full or a delete when empty is dropped with a status code.
// One command in flight: a new start is taken in the cycle after done.
// Result valid only while done is high; the receiver cannot stall.
// Synchronous reset empties the heap; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic                              cmd,
  input  wire logic signed [bmh_pkg::KEY_W-1:0] key_in,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [bmh_pkg::KEY_W-1:0]      min_out,
  output logic        [1:0]                      status,
  output logic        [bmh_pkg::OUT_CNT_W-1:0]   count_out
);

  bmh_pkg::ctl_t     ctl;
  bmh_pkg::dp_stat_t st;

  bmh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  bmh_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .key_in    (key_in),
    .ctl       (ctl),
    .st        (st),
    .min_out   (min_out),
    .status    (status),
    .count_out (count_out)
  );

endmodule

`default_nettype wire
